@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the steering block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("steering checker: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("steering checker: next-cycle implication failed");

`endif

@@ rtl/wfps_pkg.sv @@
// ---------------------------------------------------------------------------
// Wall-follow steering package
// Field widths, register indices and command constants.
// ---------------------------------------------------------------------------
package wfps_pkg;

  localparam int unsigned DistW  = 15;
  localparam int unsigned GainW  = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LinW   = 8;
  localparam int unsigned AngW   = 16;

  // Register indices on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FOLLOW_LEFT     = 3'd0,
    CFG_WALL_DISTANCE   = 3'd1,
    CFG_SAFETY_DISTANCE = 3'd2,
    CFG_GAIN_P          = 3'd3,
    CFG_GAIN_D          = 3'd4,
    CFG_GAIN_I          = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic             RST_FOLLOW_LEFT   = 1'b0;
  localparam logic [DistW-1:0] RST_WALL_DIST     = 15'd700;
  localparam logic [DistW-1:0] RST_SAFETY_DIST   = 15'd300;
  localparam logic [GainW-1:0] RST_GAIN_P        = 24'd26214;
  localparam logic [GainW-1:0] RST_GAIN_D        = 24'd1310720;
  localparam logic [GainW-1:0] RST_GAIN_I        = 24'd66;

  // Motion commands
  localparam logic [LinW-1:0]        FWD_SPEED  = 8'd200;
  localparam logic [LinW-1:0]        STOP_SPEED = 8'd0;
  localparam logic signed [AngW-1:0] SAFE_TURN  = 16'sd300;

endpackage

@@ rtl/wfps_if.sv @@
// ---------------------------------------------------------------------------
// Wall-follow steering channels
// Valid/ready channels for sensor items and motion command items.
// ---------------------------------------------------------------------------
interface wfps_in_if;
  logic                            valid;
  logic                            ready;
  logic [wfps_pkg::DistW-1:0]      left_laser_min_mm;
  logic [wfps_pkg::DistW-1:0]      left_sonar_min_mm;
  logic [wfps_pkg::DistW-1:0]      right_laser_min_mm;
  logic [wfps_pkg::DistW-1:0]      right_sonar_min_mm;
  logic [wfps_pkg::DistW-1:0]      all_laser_min_mm;
  logic [wfps_pkg::DistW-1:0]      all_sonar_min_mm;

  modport source (
    output valid, left_laser_min_mm, left_sonar_min_mm, right_laser_min_mm,
           right_sonar_min_mm, all_laser_min_mm, all_sonar_min_mm,
    input  ready
  );
  modport sink (
    input  valid, left_laser_min_mm, left_sonar_min_mm, right_laser_min_mm,
           right_sonar_min_mm, all_laser_min_mm, all_sonar_min_mm,
    output ready
  );
endinterface

interface wfps_out_if;
  logic                               valid;
  logic                               ready;
  logic [wfps_pkg::LinW-1:0]          linear_velocity_mm_s;
  logic signed [wfps_pkg::AngW-1:0]   angular_velocity_mrad_s;
  logic                               safety_turn;

  modport source (
    output valid, linear_velocity_mm_s, angular_velocity_mrad_s, safety_turn,
    input  ready
  );
  modport sink (
    input  valid, linear_velocity_mm_s, angular_velocity_mrad_s, safety_turn,
    output ready
  );
endinterface

@@ rtl/wall_follow_pid_steering.sv @@
// ---------------------------------------------------------------------------
// Wall-follow PID steering
// Turns per-period obstacle distances into forward speed and turn rate.
// ---------------------------------------------------------------------------
// Each sensor item yields one motion command item. The block is a four-stage
// pipeline (input register, error/history update, gain multipliers, sum and
// saturation into the result register): it takes one item per clock cycle
// unless every stage is full and the result is not taken. Every
// stage keeps its own valid bit, so a stalled result only holds the stages
// behind it once they fill; new items keep flowing into empty stages. The
// error history (last error, running sum) is updated as an item leaves the
// input register, so back-to-back items see each other's history in order.
// Cross-track error e is min(laser, sonar) on the followed side minus the
// wall distance; the turn rate is floor(-(kp*e + kd*de + ki*sum) / 2^16),
// clamped to 16 bits, with 200 mm/s forward. When both the all-around laser
// and sonar minima are at or below the safety distance the history is
// cleared and the command is 0 mm/s, +300 mrad/s with safety_turn set.
// Gains are unsigned Q8.16. Write configuration only while the block is idle.
// ---------------------------------------------------------------------------
module wall_follow_pid_steering #(
  parameter int unsigned SUM_WIDTH = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  wfps_in_if.sink                             in_i,
  wfps_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [wfps_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [wfps_pkg::GainW-1:0]          cfg_data_i
);

  localparam int unsigned DW   = wfps_pkg::DistW;
  localparam int unsigned GW   = wfps_pkg::GainW;
  localparam int unsigned EW   = DW + 1;      // error width
  localparam int unsigned DDW  = EW + 1;      // derivative width
  localparam int unsigned IVW  = 39;          // clamped integral operand
  localparam int unsigned ILW  = 20;          // low slice of the integral operand
  localparam int unsigned PPW  = GW + 1 + EW; // kp*e product
  localparam int unsigned PDW  = GW + 1 + DDW;// kd*de product
  localparam int unsigned PLW  = GW + ILW;    // ki*low slice product
  localparam int unsigned PHW  = GW + 1 + IVW - ILW; // ki*high slice product
  localparam int unsigned ACCW = 65;

  localparam logic signed [63:0]  ILIM_POS = 64'sd274877906944;   //  2^38
  localparam logic signed [63:0]  ILIM_NEG = -64'sd274877906944;  // -2^38
  // High partial pinned so that the whole term is +-2^50
  localparam logic signed [PHW-1:0] IHI_POS = 44'sd1073741824;    //  2^30
  localparam logic signed [PHW-1:0] IHI_NEG = -44'sd1073741824;   // -2^30
  localparam logic signed [ACCW-1:0] ANG_MAX = 65'sd32767;
  localparam logic signed [ACCW-1:0] ANG_MIN = -65'sd32768;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic          follow_left_q;
  logic [DW-1:0] wall_dist_q;
  logic [DW-1:0] safety_dist_q;
  logic [GW-1:0] gain_p_q;
  logic [GW-1:0] gain_d_q;
  logic [GW-1:0] gain_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_left_q <= wfps_pkg::RST_FOLLOW_LEFT;
      wall_dist_q   <= wfps_pkg::RST_WALL_DIST;
      safety_dist_q <= wfps_pkg::RST_SAFETY_DIST;
      gain_p_q      <= wfps_pkg::RST_GAIN_P;
      gain_d_q      <= wfps_pkg::RST_GAIN_D;
      gain_i_q      <= wfps_pkg::RST_GAIN_I;
    end else if (cfg_we_i) begin
      // Bits above a register's width are dropped; unknown indices do nothing
      unique case (wfps_pkg::cfg_idx_e'(cfg_idx_i))
        wfps_pkg::CFG_FOLLOW_LEFT:     follow_left_q <= cfg_data_i[0];
        wfps_pkg::CFG_WALL_DISTANCE:   wall_dist_q   <= cfg_data_i[DW-1:0];
        wfps_pkg::CFG_SAFETY_DISTANCE: safety_dist_q <= cfg_data_i[DW-1:0];
        wfps_pkg::CFG_GAIN_P:          gain_p_q      <= cfg_data_i;
        wfps_pkg::CFG_GAIN_D:          gain_d_q      <= cfg_data_i;
        wfps_pkg::CFG_GAIN_I:          gain_i_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor advances
  // -------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: input register
  // -------------------------------------------------------------------------
  logic [DW-1:0] ll_q, ls_q, rl_q, rs_q, al_q, as_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ll_q <= in_i.left_laser_min_mm;
      ls_q <= in_i.left_sonar_min_mm;
      rl_q <= in_i.right_laser_min_mm;
      rs_q <= in_i.right_sonar_min_mm;
      al_q <= in_i.all_laser_min_mm;
      as_q <= in_i.all_sonar_min_mm;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: cross-track error, derivative, running sum, history update
  // -------------------------------------------------------------------------
  logic signed [EW-1:0]        last_err_q;
  logic                        have_last_q;
  logic signed [SUM_WIDTH-1:0] err_sum_q;

  logic [DW-1:0]               side;
  logic signed [EW-1:0]        err;
  logic signed [DDW-1:0]       deriv;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] isum;
  logic signed [63:0]          isum_ext;
  logic                        safe;

  always_comb begin
    if (follow_left_q) begin
      side = (ll_q < ls_q) ? ll_q : ls_q;
    end else begin
      side = (rl_q < rs_q) ? rl_q : rs_q;
    end
    err   = $signed({1'b0, side}) - $signed({1'b0, wall_dist_q});
    deriv = have_last_q ? (DDW'(err) - DDW'(last_err_q)) : '0;

    // Saturate the running sum at its width
    sum_wide = (SUM_WIDTH+1)'(err_sum_q) + (SUM_WIDTH+1)'(err);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      isum = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      isum = sum_wide[SUM_WIDTH-1:0];
    end
    isum_ext = 64'(isum);

    safe = (al_q <= safety_dist_q) && (as_q <= safety_dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      have_last_q <= 1'b0;
      err_sum_q   <= '0;
    end else if (en2 && v1_q) begin
      if (safe) begin
        // Safety turn: drop all history
        last_err_q  <= '0;
        have_last_q <= 1'b0;
        err_sum_q   <= '0;
      end else begin
        last_err_q  <= err;
        have_last_q <= 1'b1;
        err_sum_q   <= isum;
      end
    end
  end

  logic signed [EW-1:0]  e2_q;
  logic signed [DDW-1:0] d2_q;
  logic signed [IVW-1:0] iv2_q;
  logic                  ihi2_q, ilo2_q, safe2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      e2_q    <= err;
      d2_q    <= deriv;
      iv2_q   <= isum_ext[IVW-1:0];
      ihi2_q  <= (isum_ext >= ILIM_POS);
      ilo2_q  <= (isum_ext <= ILIM_NEG);
      safe2_q <= safe;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: gain multipliers; the integral product is split into a high
  // and a low partial, recombined in the final sum
  // -------------------------------------------------------------------------
  logic signed [PPW-1:0] pp;
  logic signed [PDW-1:0] pd;
  logic signed [PHW-1:0] pih_prod;
  logic [PLW-1:0]        pil_prod;
  logic signed [PHW-1:0] pih;
  logic [PLW-1:0]        pil;

  always_comb begin
    pp       = PPW'($signed({1'b0, gain_p_q})) * PPW'(e2_q);
    pd       = PDW'($signed({1'b0, gain_d_q})) * PDW'(d2_q);
    pih_prod = PHW'($signed({1'b0, gain_i_q})) * PHW'($signed(iv2_q[IVW-1:ILW]));
    pil_prod = PLW'(gain_i_q) * PLW'(iv2_q[ILW-1:0]);
    // A zero gain gives no term; a huge sum saturates the output anyway: pin the term at +-2^50
    priority if (gain_i_q == '0) begin
      pih = '0;
      pil = '0;
    end else if (ihi2_q) begin
      pih = IHI_POS;
      pil = '0;
    end else if (ilo2_q) begin
      pih = IHI_NEG;
      pil = '0;
    end else begin
      pih = pih_prod;
      pil = pil_prod;
    end
  end

  logic signed [PPW-1:0] pp3_q;
  logic signed [PDW-1:0] pd3_q;
  logic signed [PHW-1:0] pih3_q;
  logic [PLW-1:0]        pil3_q;
  logic                  safe3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pp3_q   <= pp;
      pd3_q   <= pd;
      pih3_q  <= pih;
      pil3_q  <= pil;
      safe3_q <= safe2_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: sum, negate, floor shift, saturate into the result register
  // -------------------------------------------------------------------------
  logic signed [ACCW-1:0]          acc, neg, shifted;
  logic [wfps_pkg::LinW-1:0]       lin_d;
  logic signed [wfps_pkg::AngW-1:0] ang_d;

  always_comb begin
    acc     = ACCW'(pp3_q) + ACCW'(pd3_q) + (ACCW'(pih3_q) <<< ILW)
            + ACCW'($signed({1'b0, pil3_q}));
    neg     = -acc;
    shifted = neg >>> 16;  // arithmetic shift floors toward minus infinity
    if (safe3_q) begin
      lin_d = wfps_pkg::STOP_SPEED;
      ang_d = wfps_pkg::SAFE_TURN;
    end else begin
      lin_d = wfps_pkg::FWD_SPEED;
      priority if (shifted > ANG_MAX) begin
        ang_d = ANG_MAX[wfps_pkg::AngW-1:0];
      end else if (shifted < ANG_MIN) begin
        ang_d = ANG_MIN[wfps_pkg::AngW-1:0];
      end else begin
        ang_d = shifted[wfps_pkg::AngW-1:0];
      end
    end
  end

  logic [wfps_pkg::LinW-1:0]        lin_q;
  logic signed [wfps_pkg::AngW-1:0] ang_q;
  logic                             safe4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      lin_q   <= lin_d;
      ang_q   <= ang_d;
      safe4_q <= safe3_q;
    end
  end

  assign out_o.valid                   = v4_q;
  assign out_o.linear_velocity_mm_s    = lin_q;
  assign out_o.angular_velocity_mrad_s = ang_q;
  assign out_o.safety_turn             = safe4_q;

endmodule

@@ rtl/wfps_checker.sv @@
// ---------------------------------------------------------------------------
// Wall-follow steering checker
// Port-level properties of the motion command channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wfps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [wfps_pkg::LinW-1:0]         lin_i,
  input logic signed [wfps_pkg::AngW-1:0]  ang_i,
  input logic                              safety_i
);

  // Safety turn always stops and turns left at the fixed rate
  `WFPS_ASSERT_IMP(a_safe_cmd, clk_i, rst_ni, out_valid_i && safety_i, (lin_i == wfps_pkg::STOP_SPEED) && (ang_i == wfps_pkg::SAFE_TURN))

  // Normal control always drives forward at full speed
  `WFPS_ASSERT_IMP(a_fwd_cmd, clk_i, rst_ni, out_valid_i && !safety_i, lin_i == wfps_pkg::FWD_SPEED)

  // A stalled command holds until taken
  `WFPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(ang_i) && $stable(lin_i) && $stable(safety_i))

endmodule

bind wall_follow_pid_steering wfps_checker u_wfps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .lin_i       (out_o.linear_velocity_mm_s),
  .ang_i       (out_o.angular_velocity_mrad_s),
  .safety_i    (out_o.safety_turn)
);
